@@ src/nps_pkg.sv @@
// shared types, constants and helpers of the priority scheduler
`timescale 1ns / 1ps

package nps_pkg;

    // job slots
    localparam int MAX_JOBS = 16;
    localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // field widths
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 4;
    localparam int OVH_W   = 16;
    localparam int TIME_W  = 22;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // register indexes, taken from paddr[2]
    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_OVERHEAD   = 1'b1;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP,
        ST_ADD1,
        ST_ADD2,
        ST_SUB1,
        ST_SUB2,
        ST_SUB3,
        ST_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD_SAT,
        ALU_SUB_CLAMP
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } alu_req_t;

    // true when priority c beats the best value b so far
    function automatic logic prio_better(input logic desc, input logic [PRIO_W-1:0] c,
                                         input logic [PRIO_W-1:0] b);
        return desc ? (c > b) : (c < b);
    endfunction

endpackage

@@ src/nps_alu.sv @@
// shared time unit: saturating add and clamped subtract
`timescale 1ns / 1ps

module nps_alu (
    input  nps_pkg::alu_req_t          req,
    output logic [nps_pkg::TIME_W-1:0] y
);

    logic [nps_pkg::TIME_W:0] sum;

    assign sum = {1'b0, req.a} + {1'b0, req.b};

    always_comb
    begin
        unique case (req.op)
            nps_pkg::ALU_ADD_SAT:
            begin
                y = sum[nps_pkg::TIME_W] ? nps_pkg::TIME_MAX : sum[nps_pkg::TIME_W-1:0];
            end
            nps_pkg::ALU_SUB_CLAMP:
            begin
                y = (req.a > req.b) ? (req.a - req.b) : '0;
            end
            default:
            begin
                y = '0;
            end
        endcase
    end

endmodule

@@ src/nonpreemptive_priority_scheduler_top.sv @@
// top level of the non-preemptive priority scheduler
`timescale 1ns / 1ps

// channel   | direction | handshake        | beat contents
// ----------+-----------+------------------+-----------------------------------------------
// job in    | in        | in_valid/ready   | arrival, burst, priority_req, last
// result    | out       | out_valid/ready  | job_id, finish_time, completion_time,
//           |           |                  | turnaround, waiting, final_res
// config    | in        | apb, pready = 1  | 0x0 descending, 0x4 overhead
//
// loading accepts one job beat per cycle while idle; jobs beyond MAX_JOBS are dropped
// after the beat with last set, each result takes a slot ram scan over the jobs left,
// a swap, five passes through the shared time unit and the output state
// in_ready is low from the last beat until the final result enters the output
// register; that register holds a result under back-pressure and stalls the pick
// reset clears the counters, clock and configuration; slot ram needs no clearing

module nonpreemptive_priority_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [nps_pkg::ARR_W-1:0]     arrival,
    input  logic [nps_pkg::BURST_W-1:0]   burst,
    input  logic [nps_pkg::PRIO_W-1:0]    priority_req,
    input  logic                          last,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nps_pkg::ID_W-1:0]      job_id,
    output logic [nps_pkg::TIME_W-1:0]    finish_time,
    output logic [nps_pkg::TIME_W-1:0]    completion_time,
    output logic [nps_pkg::TIME_W-1:0]    turnaround,
    output logic [nps_pkg::TIME_W-1:0]    waiting,
    output logic                          final_res,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nps_pkg::ADDR_W-1:0]    paddr,
    input  logic [nps_pkg::DATA_W-1:0]    pwdata,
    output logic [nps_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // configuration registers
    logic                       desc_reg;
    logic [nps_pkg::OVH_W-1:0]  ovh_reg;
    logic                       cfg_wr;

    // control state
    nps_pkg::state_t            state_reg, state_next;
    logic [nps_pkg::CNT_W-1:0]  job_count_reg, job_count_next;
    logic [nps_pkg::CNT_W-1:0]  np_reg, np_next;        // next run position
    logic [nps_pkg::TIME_W-1:0] cur_reg, cur_next;      // schedule clock
    logic [nps_pkg::CNT_W-1:0]  issue_reg, issue_next;  // scan read pointer
    logic                       rd_vld_reg, rd_vld_next;
    logic                       fa_reg, fa_next;        // an arrived job seen
    logic                       fe_reg, fe_next;        // any job seen
    logic                       out_valid_reg, out_valid_next;

    // scan payload
    logic [nps_pkg::SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    nps_pkg::slot_t             head_reg, head_next;
    nps_pkg::slot_t             cand_a_reg, cand_a_next;
    logic [nps_pkg::SLOT_W-1:0] cand_a_idx_reg, cand_a_idx_next;
    nps_pkg::slot_t             cand_e_reg, cand_e_next;
    logic [nps_pkg::SLOT_W-1:0] cand_e_idx_reg, cand_e_idx_next;
    nps_pkg::slot_t             pick_reg, pick_next;
    logic [nps_pkg::TIME_W-1:0] start_reg, start_next;
    logic [nps_pkg::TIME_W-1:0] fin_reg, fin_next;
    logic [nps_pkg::TIME_W-1:0] comp_reg, comp_next;
    logic [nps_pkg::TIME_W-1:0] tat_reg, tat_next;
    logic [nps_pkg::TIME_W-1:0] wait_reg, wait_next;

    // output register payload
    logic                       out_load;
    logic                       out_final;
    logic [nps_pkg::ID_W-1:0]   job_id_reg;
    logic [nps_pkg::TIME_W-1:0] finish_reg;
    logic [nps_pkg::TIME_W-1:0] completion_reg;
    logic [nps_pkg::TIME_W-1:0] turnaround_reg;
    logic [nps_pkg::TIME_W-1:0] waiting_reg;
    logic                       final_reg;

    // slot ram, one write and one registered read port
    nps_pkg::slot_t             slot_mem [nps_pkg::MAX_JOBS];
    logic                       wr_en;
    logic [nps_pkg::SLOT_W-1:0] wr_addr;
    nps_pkg::slot_t             wr_data;
    logic [nps_pkg::SLOT_W-1:0] rd_addr;
    nps_pkg::slot_t             rd_data_reg;

    // shared time unit
    nps_pkg::alu_req_t          alu_req;
    logic [nps_pkg::TIME_W-1:0] alu_y;

    nps_pkg::slot_t             in_slot;
    logic                       arrived;
    logic                       e_better;

    nps_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    // ---------------- apb configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[2])
            nps_pkg::REG_DESCENDING: prdata = {{(nps_pkg::DATA_W-1){1'b0}}, desc_reg};
            nps_pkg::REG_OVERHEAD:   prdata = {{(nps_pkg::DATA_W-nps_pkg::OVH_W){1'b0}}, ovh_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
            ovh_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                nps_pkg::REG_DESCENDING: desc_reg <= pwdata[0];
                nps_pkg::REG_OVERHEAD:   ovh_reg  <= pwdata[nps_pkg::OVH_W-1:0];
                default:                 desc_reg <= desc_reg;
            endcase
        end
    end

    // ---------------- slot ram ----------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    assign in_ready = (state_reg == nps_pkg::ST_IDLE);

    always_comb
    begin
        in_slot.arrival = arrival;
        in_slot.burst   = burst;
        in_slot.prio    = priority_req;
        in_slot.id      = nps_pkg::ID_W'(job_count_reg);

        // scan compares on the beat coming out of the ram
        arrived  = (nps_pkg::TIME_W'(rd_data_reg.arrival) <= cur_reg);
        e_better = (rd_data_reg.arrival < cand_e_reg.arrival) ||
                   ((rd_data_reg.arrival == cand_e_reg.arrival) &&
                    nps_pkg::prio_better(desc_reg, rd_data_reg.prio, cand_e_reg.prio));
    end

    always_comb
    begin
        state_next      = state_reg;
        job_count_next  = job_count_reg;
        np_next         = np_reg;
        cur_next        = cur_reg;
        issue_next      = issue_reg;
        rd_vld_next     = rd_vld_reg;
        fa_next         = fa_reg;
        fe_next         = fe_reg;
        out_valid_next  = out_valid_reg;
        rd_idx_next     = rd_idx_reg;
        head_next       = head_reg;
        cand_a_next     = cand_a_reg;
        cand_a_idx_next = cand_a_idx_reg;
        cand_e_next     = cand_e_reg;
        cand_e_idx_next = cand_e_idx_reg;
        pick_next       = pick_reg;
        start_next      = start_reg;
        fin_next        = fin_reg;
        comp_next       = comp_reg;
        tat_next        = tat_reg;
        wait_next       = wait_reg;

        wr_en     = 1'b0;
        wr_addr   = job_count_reg[nps_pkg::SLOT_W-1:0];
        wr_data   = in_slot;
        rd_addr   = issue_reg[nps_pkg::SLOT_W-1:0];
        out_load  = 1'b0;
        out_final = 1'b0;

        alu_req.op = nps_pkg::ALU_ADD_SAT;
        alu_req.a  = start_reg;
        alu_req.b  = nps_pkg::TIME_W'(pick_reg.burst);

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // full slots drop the beat but still honor last
                    if (job_count_reg < nps_pkg::CNT_W'(nps_pkg::MAX_JOBS))
                    begin
                        wr_en          = 1'b1;
                        job_count_next = job_count_reg + nps_pkg::CNT_W'(1);
                    end
                    if (last)
                    begin
                        np_next     = '0;
                        cur_next    = '0;
                        issue_next  = '0;
                        rd_vld_next = 1'b0;
                        fa_next     = 1'b0;
                        fe_next     = 1'b0;
                        state_next  = nps_pkg::ST_SCAN;
                    end
                end
            end

            nps_pkg::ST_SCAN:
            begin
                if (issue_reg < job_count_reg)
                begin
                    issue_next  = issue_reg + nps_pkg::CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[nps_pkg::SLOT_W-1:0];
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end

                if (rd_vld_reg)
                begin
                    // first slot read is the run position itself
                    if (!fe_reg || e_better)
                    begin
                        cand_e_next     = rd_data_reg;
                        cand_e_idx_next = rd_idx_reg;
                    end
                    if (!fe_reg)
                    begin
                        head_next = rd_data_reg;
                        fe_next   = 1'b1;
                    end
                    if (arrived && (!fa_reg ||
                        nps_pkg::prio_better(desc_reg, rd_data_reg.prio, cand_a_reg.prio)))
                    begin
                        cand_a_next     = rd_data_reg;
                        cand_a_idx_next = rd_idx_reg;
                        fa_next         = 1'b1;
                    end
                end

                if ((issue_reg == job_count_reg) && !rd_vld_reg)
                begin
                    state_next = nps_pkg::ST_SWAP;
                end
            end

            nps_pkg::ST_SWAP:
            begin
                // head goes where the pick was; the run position is never read again
                wr_en   = 1'b1;
                wr_data = head_reg;
                if (fa_reg)
                begin
                    wr_addr    = cand_a_idx_reg;
                    pick_next  = cand_a_reg;
                    start_next = cur_reg;
                end
                else
                begin
                    // idle gap: the job starts at its own arrival
                    wr_addr    = cand_e_idx_reg;
                    pick_next  = cand_e_reg;
                    start_next = nps_pkg::TIME_W'(cand_e_reg.arrival);
                end
                state_next = nps_pkg::ST_ADD1;
            end

            nps_pkg::ST_ADD1:
            begin
                fin_next   = alu_y;
                state_next = nps_pkg::ST_ADD2;
            end

            nps_pkg::ST_ADD2:
            begin
                alu_req.a  = fin_reg;
                alu_req.b  = nps_pkg::TIME_W'(ovh_reg);
                fin_next   = alu_y;
                cur_next   = alu_y;
                state_next = nps_pkg::ST_SUB1;
            end

            nps_pkg::ST_SUB1:
            begin
                alu_req.op = nps_pkg::ALU_SUB_CLAMP;
                alu_req.a  = fin_reg;
                alu_req.b  = nps_pkg::TIME_W'(ovh_reg);
                comp_next  = alu_y;
                state_next = nps_pkg::ST_SUB2;
            end

            nps_pkg::ST_SUB2:
            begin
                alu_req.op = nps_pkg::ALU_SUB_CLAMP;
                alu_req.a  = comp_reg;
                alu_req.b  = nps_pkg::TIME_W'(pick_reg.arrival);
                tat_next   = alu_y;
                state_next = nps_pkg::ST_SUB3;
            end

            nps_pkg::ST_SUB3:
            begin
                alu_req.op = nps_pkg::ALU_SUB_CLAMP;
                alu_req.a  = tat_reg;
                alu_req.b  = nps_pkg::TIME_W'(pick_reg.burst);
                wait_next  = alu_y;
                state_next = nps_pkg::ST_OUT;
            end

            nps_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_final      = ((np_reg + nps_pkg::CNT_W'(1)) == job_count_reg);
                    out_valid_next = 1'b1;
                    np_next        = np_reg + nps_pkg::CNT_W'(1);
                    if (out_final)
                    begin
                        job_count_next = '0;
                        np_next        = '0;
                        cur_next       = '0;
                        state_next     = nps_pkg::ST_IDLE;
                    end
                    else
                    begin
                        issue_next  = np_reg + nps_pkg::CNT_W'(1);
                        rd_vld_next = 1'b0;
                        fa_next     = 1'b0;
                        fe_next     = 1'b0;
                        state_next  = nps_pkg::ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = nps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nps_pkg::ST_IDLE;
            job_count_reg <= '0;
            np_reg        <= '0;
            cur_reg       <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            fa_reg        <= 1'b0;
            fe_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            np_reg        <= np_next;
            cur_reg       <= cur_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            fa_reg        <= fa_next;
            fe_reg        <= fe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        head_reg       <= head_next;
        cand_a_reg     <= cand_a_next;
        cand_a_idx_reg <= cand_a_idx_next;
        cand_e_reg     <= cand_e_next;
        cand_e_idx_reg <= cand_e_idx_next;
        pick_reg       <= pick_next;
        start_reg      <= start_next;
        fin_reg        <= fin_next;
        comp_reg       <= comp_next;
        tat_reg        <= tat_next;
        wait_reg       <= wait_next;
        if (out_load)
        begin
            job_id_reg     <= pick_reg.id;
            finish_reg     <= fin_reg;
            completion_reg <= comp_reg;
            turnaround_reg <= tat_reg;
            waiting_reg    <= wait_reg;
            final_reg      <= out_final;
        end
    end

    // ---------------- result beat ----------------
    assign out_valid       = out_valid_reg;
    assign job_id          = job_id_reg;
    assign finish_time     = finish_reg;
    assign completion_time = completion_reg;
    assign turnaround      = turnaround_reg;
    assign waiting         = waiting_reg;
    assign final_res       = final_reg;

    // ---------------- assertions ----------------
    // while scheduling, a job is always left to place
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nps_pkg::ST_IDLE) |-> (np_reg < job_count_reg))
    else $error("run position reached job count while scheduling");

    // slot count never passes the slot capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        job_count_reg <= nps_pkg::CNT_W'(nps_pkg::MAX_JOBS))
    else $error("job count beyond slot capacity");

    // the final result hands the block back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_final) |=> (in_ready && (job_count_reg == '0)))
    else $error("block not idle after final result");

    // overhead only ever lowers the completion time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (completion_time <= finish_time))
    else $error("completion time above finish time");

endmodule
